/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* src/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared types, constants and the switch classifier of the frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  localparam int FRAME_LEN = 23;
  localparam int DATA_LEN  = 22;
  localparam int NUM_CH    = 16;
  localparam int CH_W      = 11;
  localparam int CNT_W     = 5;
  localparam int CH_IDX_W  = 4;
  localparam int SW_W      = 2;
  localparam int DATA_BITS = DATA_LEN * 8;
  localparam int FLAGS_IDX = FRAME_LEN - 1;

  localparam logic [CNT_W-1:0]    LAST_BYTE_IDX = CNT_W'(FRAME_LEN - 1);
  localparam logic [CH_IDX_W-1:0] LAST_CH       = CH_IDX_W'(NUM_CH - 1);

  localparam logic [7:0] LINK_DOWN_MASK = 8'h0C;  // lost frame | failsafe

  localparam logic [CH_W-1:0] SW_MIN     = 11'd353;
  localparam logic [CH_W-1:0] SW_UP_MAX  = 11'd600;
  localparam logic [CH_W-1:0] SW_MID_MAX = 11'd1100;
  localparam logic [CH_W-1:0] SW_MAX     = 11'd1695;

  localparam logic [7:0] HEADER_RST = 8'h0F;
  localparam logic [7:0] FOOTER_RST = 8'h00;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_FOOTER = 1'b1;

  typedef logic [SW_W-1:0] sw_pos_t;
  localparam sw_pos_t SW_UP      = 2'd0;
  localparam sw_pos_t SW_MIDDLE  = 2'd1;
  localparam sw_pos_t SW_DOWN    = 2'd2;
  localparam sw_pos_t SW_INVALID = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_STORE = 3'b010,
    PH_CHECK = 3'b100
  } phase_t;

  typedef struct packed {
    logic                 load;
    logic                 link_ok;
    logic [DATA_BITS-1:0] data;
  } frame_t;

  function automatic sw_pos_t classify_switch(input logic [CH_W-1:0] v);
    sw_pos_t pos;
    if (v < SW_MIN || v > SW_MAX) begin
      pos = SW_INVALID;
    end else if (v <= SW_UP_MAX) begin
      pos = SW_UP;
    end else if (v <= SW_MID_MAX) begin
      pos = SW_MIDDLE;
    end else begin
      pos = SW_DOWN;
    end
    return pos;
  endfunction

endpackage

/* src/sbfr_capture.sv */
// ----------------------------------------------------------------------------
// sbfr_capture
// Header hunt, frame byte store and footer check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfr_capture (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_acc,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      header_byte,
  input  logic [7:0]      footer_byte,
  output logic            in_check,
  output sbfr_pkg::frame_t frame
);
  import sbfr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       mem_r [FRAME_LEN];
  logic             wr_en;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    if (byte_acc) begin
      case (phase_r)
        PH_STORE: begin
          wr_en = (cnt_r <= LAST_BYTE_IDX);
          if (cnt_r >= LAST_BYTE_IDX) begin
            phase_nxt = PH_CHECK;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = (rx_byte == header_byte) ? PH_STORE : PH_HUNT;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[cnt_r] <= rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_LEN; i++) begin
      frame.data[8*i +: 8] = mem_r[i];
    end
    frame.link_ok = ((mem_r[FLAGS_IDX] & LINK_DOWN_MASK) != LINK_DOWN_MASK);
    frame.load    = byte_acc && (phase_r == PH_CHECK) && (rx_byte == footer_byte);
  end

  assign in_check = (phase_r == PH_CHECK);

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > LAST_BYTE_IDX)
  `ASSERT_CLK(a_store_to_check, clk, rst_n,
    (byte_acc && phase_r == PH_STORE && cnt_r == LAST_BYTE_IDX) |=> phase_r == PH_CHECK)

endmodule

/* src/sbfr_emit.sv */
// ----------------------------------------------------------------------------
// sbfr_emit
// Frame snapshot, channel unpack and classify, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfr_emit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbfr_pkg::frame_t               frame,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sbfr_pkg::CH_IDX_W-1:0]  ch_index,
  output logic [sbfr_pkg::CH_W-1:0]      ch_value,
  output logic [sbfr_pkg::SW_W-1:0]      sw_pos,
  output logic                           link_ok,
  output logic                           ch_last
);
  import sbfr_pkg::*;

  logic [DATA_BITS-1:0] snap_r;
  logic                 link_r;
  logic                 busy_r;
  logic [CH_IDX_W-1:0]  ch_r;
  logic                 ov_r;
  logic [CH_IDX_W-1:0]  oidx_r;
  logic [CH_W-1:0]      oval_r;
  sw_pos_t              osw_r;
  logic                 olink_r;
  logic                 olast_r;

  logic                 out_free;
  logic                 emit;
  logic [CH_W-1:0]      cur_val;

  assign out_free = !ov_r || out_ready;
  assign emit     = busy_r && out_free;
  assign cur_val  = snap_r[CH_W*ch_r +: CH_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ch_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (frame.load) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
      end else if (emit) begin
        ch_r <= ch_r + 1'b1;
        if (ch_r == LAST_CH) begin
          busy_r <= 1'b0;
        end
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.load) begin
      snap_r <= frame.data;
      link_r <= frame.link_ok;
    end
    if (emit) begin
      oidx_r  <= ch_r;
      oval_r  <= cur_val;
      osw_r   <= classify_switch(cur_val);
      olink_r <= link_r;
      olast_r <= (ch_r == LAST_CH);
    end
  end

  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign ch_index  = oidx_r;
  assign ch_value  = oval_r;
  assign sw_pos    = osw_r;
  assign link_ok   = olink_r;
  assign ch_last   = olast_r;

  `ASSERT_NEVER(a_load_while_busy, clk, rst_n, frame.load && busy_r)
  `ASSERT_CLK(a_load_starts_burst, clk, rst_n, frame.load |=> busy_r && ch_r == '0)
  `ASSERT_CLK(a_burst_ends_last, clk, rst_n, $fell(busy_r) |-> ov_r && olast_r)

endmodule

/* src/sbus_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// sbus_frame_receiver_core
// 16-channel serial bus frame receiver: one byte in per transfer, sixteen
// classified channel results out per good frame.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle. After the header byte, 23 bytes are
// stored (22 channel bytes, one flags byte) and the next byte is checked
// against the footer. On a match the frame is snapshotted and its sixteen
// 11-bit channels leave one per cycle while out_tready allows, the sixteenth
// with out_tlast set; a wrong footer drops the frame silently. Input is stalled
// only when a footer byte arrives while the previous frame's sixteen results
// have not yet all been moved into the output register. Header and footer
// values must be written through cfg_* while idle; the block does not enforce it.
module sbus_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                  // [16:15] switch_position, [17] link_ok, zero fill
  output logic        out_tlast   // frame_last
);
  import sbfr_pkg::*;

  logic [7:0]          header_r;
  logic [7:0]          footer_r;
  logic                byte_acc;
  logic                in_check;
  logic                emit_busy;
  frame_t              frame;
  logic [CH_IDX_W-1:0] ch_index;
  logic [CH_W-1:0]     ch_value;
  logic [SW_W-1:0]     sw_pos;
  logic                link_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_FOOTER: footer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !(in_check && emit_busy);
  assign byte_acc  = in_tvalid && in_tready;

  sbfr_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .rx_byte     (in_tdata),
    .header_byte (header_r),
    .footer_byte (footer_r),
    .in_check    (in_check),
    .frame       (frame)
  );

  sbfr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .busy      (emit_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ch_index  (ch_index),
    .ch_value  (ch_value),
    .sw_pos    (sw_pos),
    .link_ok   (link_ok),
    .ch_last   (out_tlast)
  );

  assign out_tdata = {6'b0, link_ok, sw_pos, ch_value, ch_index};

endmodule

/* bench/sbfr_channel_checker.sv */
// ----------------------------------------------------------------------------
// sbfr_channel_checker
// Watches the frame receiver's ports and checks every channel result.
// ----------------------------------------------------------------------------
// Follows the header/footer register writes and every accepted byte with its
// own copy of the frame decoder. A good footer queues sixteen predicted
// channel results. Each result transfer is compared field by field against
// the oldest queued one. Mismatch count, queue depth and "frame in progress"
// go back to the test top.
module sbfr_channel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [3:0] channel_index, [14:4] channel_value,
                                  // [16:15] switch_position, [17] link_ok
  input  logic        out_tlast,  // frame_last
  output int          mismatches,
  output int          outstanding,
  output logic        frame_open
);

  timeunit 1ns;
  timeprecision 1ps;

  import sbfr_pkg::*;

  typedef struct packed {
    logic [CH_IDX_W-1:0] index;
    logic [CH_W-1:0]     value;
    sw_pos_t             zone;
    logic                link_ok;
    logic                last;
  } channel_result_t;

  channel_result_t expected_channels[$];

  logic [7:0]       header_val;
  logic [7:0]       footer_val;
  phase_t           rx_phase;
  logic [CNT_W-1:0] stored;
  logic [7:0]       frame_mem [FRAME_LEN];

  function automatic sw_pos_t switch_zone(input logic [CH_W-1:0] v);
    if (v < SW_MIN || v > SW_MAX) return SW_INVALID;
    if (v <= SW_UP_MAX) return SW_UP;
    if (v <= SW_MID_MAX) return SW_MIDDLE;
    return SW_DOWN;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Advance the decoder by one received byte.
  task automatic decode_byte(input logic [7:0] b);
    logic [DATA_BITS-1:0] payload;
    logic                 link;
    channel_result_t      res;
    case (rx_phase)
      PH_STORE: begin
        frame_mem[stored] = b;
        if (stored == LAST_BYTE_IDX) begin
          stored   = '0;
          rx_phase = PH_CHECK;
        end else begin
          stored = stored + 1'b1;
        end
      end
      PH_CHECK: begin
        if (b == footer_val) begin
          for (int i = 0; i < DATA_LEN; i++) payload[8*i +: 8] = frame_mem[i];
          link = (frame_mem[FLAGS_IDX] & LINK_DOWN_MASK) != LINK_DOWN_MASK;
          for (int ch = 0; ch < NUM_CH; ch++) begin
            res.index   = CH_IDX_W'(ch);
            res.value   = payload[CH_W*ch +: CH_W];
            res.zone    = switch_zone(res.value);
            res.link_ok = link;
            res.last    = (ch == NUM_CH - 1);
            expected_channels.push_back(res);
          end
        end
        rx_phase = PH_HUNT;
      end
      default: begin
        rx_phase = (b == header_val) ? PH_STORE : PH_HUNT;
        stored   = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      header_val = 8'h0F;
      footer_val = 8'h00;
      rx_phase   = PH_HUNT;
      stored     = '0;
      mismatches = 0;
      expected_channels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_HEADER) header_val = cfg_wdata;
        else footer_val = cfg_wdata;
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_channels.size() == 0) begin
          report_mismatch("unexpected result, channel", int'(out_tdata[3:0]), -1);
        end else begin
          channel_result_t want;
          want = expected_channels.pop_front();
          compare_field("channel_index", int'(out_tdata[3:0]), int'(want.index));
          compare_field("channel_value", int'(out_tdata[14:4]), int'(want.value));
          compare_field("switch_position", int'(out_tdata[16:15]), int'(want.zone));
          compare_field("link_ok", int'(out_tdata[17]), int'(want.link_ok));
          compare_field("frame_last", int'(out_tlast), int'(want.last));
        end
      end
    end
    outstanding = expected_channels.size();
    frame_open  = (rx_phase != PH_HUNT);
  end

endmodule

/* bench/sbus_frame_receiver_core_test.sv */
// ----------------------------------------------------------------------------
// sbus_frame_receiver_core_test
// Stimulus and verdict for the serial bus frame receiver.
// ----------------------------------------------------------------------------
// Feeds noise, directed frames (switch thresholds, header bytes inside the
// data, link flags, bad footer) and then random frames, truncated frames and
// noise under several header/footer settings. Both stream sides idle at
// random, except under the third setting. The checker does all prediction and comparison.
module sbus_frame_receiver_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import sbfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FRAME_BITS  = FRAME_LEN * 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [7:0]  cfg_wdata  = 8'h00;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int   mismatches;
  int   outstanding;
  logic frame_open;

  int         gap_pct     = 34;
  int         stall_pct   = 34;
  int         cycle_count = 0;
  int         frame_items = 0;
  logic [7:0] cur_header  = 8'h0F;
  logic [7:0] cur_footer  = 8'h00;

  sbus_frame_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sbfr_channel_checker frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .frame_open  (frame_open)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Ends at the rising edge of the transfer; tvalid stays up for the caller.
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(input logic addr, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_frame(input logic [FRAME_BITS-1:0] body, input logic good_footer);
    push_byte(cur_header);
    for (int i = 0; i < FRAME_LEN; i++) push_byte(body[8*i +: 8]);
    push_byte(good_footer ? cur_footer : cur_footer ^ 8'($urandom_range(1, 255)));
    frame_items += FRAME_LEN + 2;
  endtask

  // Back to header hunting with no result in flight.
  task automatic drain_to_idle();
    release_bus();
    while (frame_open) begin
      push_byte(cur_header ^ 8'h01);
      release_bus();
    end
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    logic [CH_W-1:0] bound_v;
    case ($urandom_range(3))
      0:       bound_v = SW_MIN;
      1:       bound_v = SW_UP_MAX;
      2:       bound_v = SW_MID_MAX;
      default: bound_v = SW_MAX;
    endcase
    if ($urandom_range(1) == 1) return bound_v + CH_W'($urandom_range(2)) - 11'd1;
    return CH_W'($urandom_range(2047));
  endfunction

  task automatic random_burst();
    logic [NUM_CH-1:0][CH_W-1:0] chans;
    logic [FRAME_BITS-1:0]       body;
    logic [7:0]                  flags;
    int                          roll;
    int                          cut;
    roll = $urandom_range(99);
    if (roll < 15) begin
      // line noise while hunting
      repeat ($urandom_range(1, 3)) push_byte(cur_header ^ 8'($urandom_range(1, 255)));
    end else if (roll < 25) begin
      // truncated frame: the next header lands in its data
      cut = $urandom_range(1, FRAME_LEN - 1);
      push_byte(cur_header);
      repeat (cut) push_byte(8'($urandom_range(255)));
      frame_items += cut + 1;
    end else begin
      if ($urandom_range(1) == 1) begin
        for (int ch = 0; ch < NUM_CH; ch++) chans[ch] = pick_channel();
        body[DATA_BITS-1:0] = chans;
      end else begin
        for (int i = 0; i < DATA_LEN; i++) body[8*i +: 8] = 8'($urandom_range(255));
      end
      flags = 8'($urandom_range(255));
      if ($urandom_range(2) == 0) flags = flags | LINK_DOWN_MASK;
      body[8*FLAGS_IDX +: 8] = flags;
      send_frame(body, $urandom_range(99) < 80);
    end
  endtask

  task automatic apply_setting(input int p);
    logic [7:0] hdr;
    logic [7:0] ftr;
    case (p)
      0:       begin hdr = 8'h00; ftr = 8'hFF; end
      1:       begin hdr = 8'hFF; ftr = 8'h00; end
      2:       begin hdr = 8'hA5; ftr = 8'h5A; end
      3:       begin hdr = 8'h3C; ftr = 8'h3C; end
      default: begin hdr = 8'($urandom_range(255)); ftr = 8'($urandom_range(255)); end
    endcase
    drain_to_idle();
    cfg_write(CFG_HEADER, hdr);
    cfg_write(CFG_FOOTER, ftr);
    cur_header = hdr;
    cur_footer = ftr;
  endtask

  initial begin
    logic [NUM_CH-1:0][CH_W-1:0] chans;
    logic [FRAME_BITS-1:0]       body;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of header and footer in use
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h0E);

    // switch thresholds, link down
    chans = {11'd1500, 11'd512, 11'd1024, 11'd1023, 11'd2047, 11'd1696, 11'd1695, 11'd1694,
             11'd1101, 11'd1100, 11'd601, 11'd600, 11'd354, 11'd353, 11'd352, 11'd0};
    body = {8'h0C, chans};
    send_frame(body, 1'b1);

    // header value inside the data, bad footer drops it
    send_frame({FRAME_LEN{8'h0F}}, 1'b0);

    // all ones, only the lost-frame bit clear
    body = {8'hF7, {DATA_LEN{8'hFF}}};
    send_frame(body, 1'b1);

    // all zeros, failsafe bit alone
    body = {8'h04, {DATA_LEN{8'h00}}};
    send_frame(body, 1'b1);

    frame_items = 0;
    for (int p = 0; p < 5; p++) begin
      apply_setting(p);
      gap_pct   = (p == 2) ? 0 : 34;
      stall_pct = (p == 2) ? 0 : 34;
      while (frame_items < 50 * (p + 1)) random_burst();
    end

    release_bus();
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
